/* design/euler_zyx_to_homogeneous_transform_top_macros.svh */
// Assertion macros for the pose-to-transform block.
// Used by the top level; expects a clock and a reset signal in scope.
`ifndef EULER_ZYX_TO_HOMOGENEOUS_TRANSFORM_TOP_MACROS_SVH
`define EULER_ZYX_TO_HOMOGENEOUS_TRANSFORM_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EZH_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ezh assertion failed");

// Next-cycle implication, checked outside reset.
`define EZH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ezh assertion failed");

`endif

/* design/ezh_pkg.sv */
// Package for the pose-to-transform block: widths, types, CORDIC table, rounding.
// No dependencies.
`timescale 1ns / 1ps

package ezh_pkg;

   localparam int ANGLE_WIDTH  = 16;
   localparam int COEF_WIDTH   = 16;
   localparam int COEF_FRAC    = COEF_WIDTH - 2;
   localparam int ANG_PAD      = 32 - ANGLE_WIDTH;
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
   localparam int MATRIX_LAT   = 5;
   localparam int XY_W         = 33;
   localparam int Z_W          = 32;
   localparam int NAR_W        = XY_W + 1;
   localparam int PROD_W       = 2 * XY_W;
   localparam int SUM_W        = PROD_W + 1;
   localparam int SH_WIDE      = 60 - COEF_FRAC;
   localparam int SH_NARROW    = 30 - COEF_FRAC;

   typedef logic signed [31:0]             trans_type;
   typedef logic signed [ANGLE_WIDTH-1:0]  angle_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [XY_W-1:0]         xy_type;
   typedef logic signed [Z_W-1:0]          z_type;
   typedef logic signed [NAR_W-1:0]        nar_type;
   typedef logic signed [PROD_W-1:0]       prod_type;
   typedef logic signed [SUM_W-1:0]        sum_type;

   // Quadrant codes taken from the top two bits of the binary angle.
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam xy_type   CORDIC_START = 33'sd652032874;
   localparam prod_type HALF_Q30     = prod_type'(1) <<< 29;
   localparam sum_type  HALF_WIDE    = sum_type'(1) <<< (SH_WIDE - 1);
   localparam nar_type  HALF_NARROW  = nar_type'(1) <<< (SH_NARROW - 1);
   localparam sum_type  LIM_WIDE     = sum_type'(1) <<< COEF_FRAC;
   localparam nar_type  LIM_NARROW   = nar_type'(1) <<< COEF_FRAC;

   // Arctangent of 2^-i in units of 2^32 per turn.
   localparam z_type ATAN_TAB [CORDIC_STEPS] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
      32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
      32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
      32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
      32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
   };

   typedef struct packed {
      xy_type c;
      xy_type s;
   } sincos_type;

   typedef struct packed {
      coef_type  rot_00;
      coef_type  rot_01;
      coef_type  rot_02;
      coef_type  rot_10;
      coef_type  rot_11;
      coef_type  rot_12;
      coef_type  rot_20;
      coef_type  rot_21;
      coef_type  rot_22;
      trans_type out_x;
      trans_type out_y;
      trans_type out_z;
   } rsp_type;

   // Round a Q60 sum to the coefficient format and saturate to plus or minus one.
   function automatic coef_type round_wide(sum_type v);
      sum_type r;
      r = (v + HALF_WIDE) >>> SH_WIDE;
      if (r > LIM_WIDE) begin
         r = LIM_WIDE;
      end else if (r < -LIM_WIDE) begin
         r = -LIM_WIDE;
      end
      return r[COEF_WIDTH-1:0];
   endfunction

   // Same for a Q30 value.
   function automatic coef_type round_narrow(nar_type v);
      nar_type r;
      r = (v + HALF_NARROW) >>> SH_NARROW;
      if (r > LIM_NARROW) begin
         r = LIM_NARROW;
      end else if (r < -LIM_NARROW) begin
         r = -LIM_NARROW;
      end
      return r[COEF_WIDTH-1:0];
   endfunction

endpackage

/* design/ezh_req_if.sv */
// Request channel interface: one pose per transaction.
// Depends on ezh_pkg.
`timescale 1ns / 1ps

interface ezh_req_if;
   import ezh_pkg::*;

   logic      valid;
   logic      ready;
   trans_type trans_x;
   trans_type trans_y;
   trans_type trans_z;
   angle_type yaw_angle;
   angle_type pitch_angle;
   angle_type roll_angle;

   modport source (output valid, output trans_x, output trans_y, output trans_z,
                   output yaw_angle, output pitch_angle, output roll_angle,
                   input ready);
   modport sink   (input valid, input trans_x, input trans_y, input trans_z,
                   input yaw_angle, input pitch_angle, input roll_angle,
                   output ready);
endinterface

/* design/ezh_rsp_if.sv */
// Response channel interface: one transform per transaction.
// Depends on ezh_pkg.
`timescale 1ns / 1ps

interface ezh_rsp_if;
   import ezh_pkg::*;

   logic      valid;
   logic      ready;
   coef_type  rot_00;
   coef_type  rot_01;
   coef_type  rot_02;
   coef_type  rot_10;
   coef_type  rot_11;
   coef_type  rot_12;
   coef_type  rot_20;
   coef_type  rot_21;
   coef_type  rot_22;
   trans_type out_x;
   trans_type out_y;
   trans_type out_z;

   modport source (output valid, output rot_00, output rot_01, output rot_02,
                   output rot_10, output rot_11, output rot_12, output rot_20,
                   output rot_21, output rot_22, output out_x, output out_y,
                   output out_z, input ready);
   modport sink   (input valid, input rot_00, input rot_01, input rot_02,
                   input rot_10, input rot_11, input rot_12, input rot_20,
                   input rot_21, input rot_22, input out_x, input out_y,
                   input out_z, output ready);
endinterface

/* design/ezh_cordic.sv */
// Pipelined rotation-mode CORDIC: one iteration per stage, then quadrant fold.
// Depends on ezh_pkg.
`timescale 1ns / 1ps

module ezh_cordic (
   input  logic                clock,
   input  logic                en,
   input  ezh_pkg::angle_type  angle,
   output ezh_pkg::sincos_type sc
);
   import ezh_pkg::*;

   logic [31:0] ang;
   xy_type      x_ff [CORDIC_STEPS];
   xy_type      y_ff [CORDIC_STEPS];
   z_type       z_ff [CORDIC_STEPS];
   logic [1:0]  q_ff [CORDIC_STEPS];
   sincos_type  sc_ff;
   sincos_type  sc_in;

   // Extend to a 32-bit binary angle covering one full turn.
   assign ang = {angle, {ANG_PAD{1'b0}}};

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      xy_type     xp, yp, x_in, y_in;
      z_type      zp, z_in;
      logic [1:0] qp;

      if (i == 0) begin : g_first
         assign xp = CORDIC_START;
         assign yp = '0;
         assign zp = {2'b00, ang[29:0]};
         assign qp = ang[31:30];
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign qp = q_ff[i-1];
      end

      // One micro-rotation, direction set by the sign of the residual angle.
      always_comb begin
         if (!zp[Z_W-1]) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - ATAN_TAB[i];
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
            q_ff[i] <= qp;
         end
      end
   end

   // Map the first-quadrant result to the full circle.
   always_comb begin
      case (q_ff[CORDIC_STEPS-1])
         QUAD_0: begin
            sc_in.c = x_ff[CORDIC_STEPS-1];
            sc_in.s = y_ff[CORDIC_STEPS-1];
         end
         QUAD_1: begin
            sc_in.c = -y_ff[CORDIC_STEPS-1];
            sc_in.s = x_ff[CORDIC_STEPS-1];
         end
         QUAD_2: begin
            sc_in.c = -x_ff[CORDIC_STEPS-1];
            sc_in.s = -y_ff[CORDIC_STEPS-1];
         end
         default: begin
            sc_in.c = y_ff[CORDIC_STEPS-1];
            sc_in.s = -x_ff[CORDIC_STEPS-1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff <= sc_in;
      end
   end

   assign sc = sc_ff;

endmodule

/* design/ezh_matrix.sv */
// Rotation matrix pipeline: products, rounding, second products, sums, output rounding.
// Depends on ezh_pkg.
`timescale 1ns / 1ps

module ezh_matrix (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_in,
   input  ezh_pkg::sincos_type yaw,
   input  ezh_pkg::sincos_type pitch,
   input  ezh_pkg::sincos_type roll,
   input  ezh_pkg::trans_type  trans_x,
   input  ezh_pkg::trans_type  trans_y,
   input  ezh_pkg::trans_type  trans_z,
   output logic                valid_out,
   output ezh_pkg::rsp_type    result
);
   import ezh_pkg::*;

   logic      v_ff [MATRIX_LAT];
   trans_type tx_ff [MATRIX_LAT-1];
   trans_type ty_ff [MATRIX_LAT-1];
   trans_type tz_ff [MATRIX_LAT-1];

   // Products and factors per stage; csp and ssp each feed two entries.
   prod_type cycp_ff [3], sycp_ff [3], sycr_ff [3], sysr_ff [3];
   prod_type cycr_ff [3], cysr_ff [3], cpsr_ff [3], cpcr_ff [3];
   prod_type cysp_ff, sysp_ff;
   xy_type   sp_ff [3], sr_ff [2], cr_ff [2];
   xy_type   csp_ff, ssp_ff;
   prod_type cspsr_ff, cspcr_ff, sspsr_ff, sspcr_ff;
   sum_type  s00_ff, s01_ff, s02_ff, s10_ff, s11_ff, s12_ff, s21_ff, s22_ff;
   nar_type  n20_ff;
   rsp_type  res_ff;
   prod_type csp_full, ssp_full;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MATRIX_LAT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= valid_in;
         for (int i = 1; i < MATRIX_LAT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // Translations ride along unchanged.
   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff[0] <= trans_x;
         ty_ff[0] <= trans_y;
         tz_ff[0] <= trans_z;
         for (int i = 1; i < MATRIX_LAT - 1; i++) begin
            tx_ff[i] <= tx_ff[i-1];
            ty_ff[i] <= ty_ff[i-1];
            tz_ff[i] <= tz_ff[i-1];
         end
      end
   end

   // Round the yaw-pitch products back to Q30 for the three-factor terms.
   assign csp_full = (cysp_ff + HALF_Q30) >>> 30;
   assign ssp_full = (sysp_ff + HALF_Q30) >>> 30;

   always_ff @(posedge clock) begin
      if (en) begin
         // Stage 1: two-factor products in Q60.
         cycp_ff[0] <= yaw.c * pitch.c;
         sycp_ff[0] <= yaw.s * pitch.c;
         sycr_ff[0] <= yaw.s * roll.c;
         sysr_ff[0] <= yaw.s * roll.s;
         cycr_ff[0] <= yaw.c * roll.c;
         cysr_ff[0] <= yaw.c * roll.s;
         cpsr_ff[0] <= pitch.c * roll.s;
         cpcr_ff[0] <= pitch.c * roll.c;
         cysp_ff    <= yaw.c * pitch.s;
         sysp_ff    <= yaw.s * pitch.s;
         sp_ff[0]   <= pitch.s;
         sr_ff[0]   <= roll.s;
         cr_ff[0]   <= roll.c;

         // Stage 2: rounding of the shared factors.
         csp_ff     <= csp_full[XY_W-1:0];
         ssp_ff     <= ssp_full[XY_W-1:0];
         cycp_ff[1] <= cycp_ff[0];
         sycp_ff[1] <= sycp_ff[0];
         sycr_ff[1] <= sycr_ff[0];
         sysr_ff[1] <= sysr_ff[0];
         cycr_ff[1] <= cycr_ff[0];
         cysr_ff[1] <= cysr_ff[0];
         cpsr_ff[1] <= cpsr_ff[0];
         cpcr_ff[1] <= cpcr_ff[0];
         sp_ff[1]   <= sp_ff[0];
         sr_ff[1]   <= sr_ff[0];
         cr_ff[1]   <= cr_ff[0];

         // Stage 3: products with the roll terms.
         cspsr_ff   <= csp_ff * sr_ff[1];
         cspcr_ff   <= csp_ff * cr_ff[1];
         sspsr_ff   <= ssp_ff * sr_ff[1];
         sspcr_ff   <= ssp_ff * cr_ff[1];
         cycp_ff[2] <= cycp_ff[1];
         sycp_ff[2] <= sycp_ff[1];
         sycr_ff[2] <= sycr_ff[1];
         sysr_ff[2] <= sysr_ff[1];
         cycr_ff[2] <= cycr_ff[1];
         cysr_ff[2] <= cysr_ff[1];
         cpsr_ff[2] <= cpsr_ff[1];
         cpcr_ff[2] <= cpcr_ff[1];
         sp_ff[2]   <= sp_ff[1];

         // Stage 4: exact Q60 sums.
         s00_ff <= SUM_W'(cycp_ff[2]);
         s10_ff <= SUM_W'(sycp_ff[2]);
         s01_ff <= SUM_W'(cspsr_ff) - SUM_W'(sycr_ff[2]);
         s02_ff <= SUM_W'(cspcr_ff) + SUM_W'(sysr_ff[2]);
         s11_ff <= SUM_W'(sspsr_ff) + SUM_W'(cycr_ff[2]);
         s12_ff <= SUM_W'(sspcr_ff) - SUM_W'(cysr_ff[2]);
         s21_ff <= SUM_W'(cpsr_ff[2]);
         s22_ff <= SUM_W'(cpcr_ff[2]);
         n20_ff <= -NAR_W'(sp_ff[2]);

         // Stage 5: round and saturate every entry.
         res_ff.rot_00 <= round_wide(s00_ff);
         res_ff.rot_01 <= round_wide(s01_ff);
         res_ff.rot_02 <= round_wide(s02_ff);
         res_ff.rot_10 <= round_wide(s10_ff);
         res_ff.rot_11 <= round_wide(s11_ff);
         res_ff.rot_12 <= round_wide(s12_ff);
         res_ff.rot_20 <= round_narrow(n20_ff);
         res_ff.rot_21 <= round_wide(s21_ff);
         res_ff.rot_22 <= round_wide(s22_ff);
         res_ff.out_x  <= tx_ff[MATRIX_LAT-2];
         res_ff.out_y  <= ty_ff[MATRIX_LAT-2];
         res_ff.out_z  <= tz_ff[MATRIX_LAT-2];
      end
   end

   assign valid_out = v_ff[MATRIX_LAT-1];
   assign result    = res_ff;

endmodule

/* design/euler_zyx_to_homogeneous_transform_top.sv */
// Channel   Dir  Transaction
// req_chan  in   translations plus yaw, pitch and roll binary angles
// rsp_chan  out  nine Q2.14 rotation entries plus the passed-through translations
//
// One transaction enters per cycle while req ready is high; a request passes through 37
// register stages before its response is valid: 31 stages of CORDIC (one iteration
// each plus a quadrant fold), 5 matrix stages and the output register. Reset is
// synchronous and clears only valid bits.
// A stalled response fills a one-entry skid buffer; only then does req ready drop.
// Depends on ezh_pkg, ezh_req_if, ezh_rsp_if, ezh_cordic, ezh_matrix and the macros.
`timescale 1ns / 1ps
`include "euler_zyx_to_homogeneous_transform_top_macros.svh"

module euler_zyx_to_homogeneous_transform_top (
   input  logic       clock,
   input  logic       reset,
   ezh_req_if.sink    req_chan,
   ezh_rsp_if.source  rsp_chan
);
   import ezh_pkg::*;

   logic       adv;
   logic       dv_ff [CORDIC_LAT];
   trans_type  dx_ff [CORDIC_LAT];
   trans_type  dy_ff [CORDIC_LAT];
   trans_type  dz_ff [CORDIC_LAT];
   sincos_type yaw_sc, pitch_sc, roll_sc;
   logic       m_valid;
   rsp_type    m_result;
   rsp_type    out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;
   logic       rsp_fire;

   // The pipeline moves whenever the skid buffer is free.
   assign adv            = !skid_valid_ff;
   assign req_chan.ready = adv;
   assign rsp_fire       = out_valid_ff & rsp_chan.ready;

   // Valid bits alongside the CORDIC stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORDIC_LAT; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= req_chan.valid;
         for (int i = 1; i < CORDIC_LAT; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
   end

   // Translations delayed to line up with the sines and cosines.
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff[0] <= req_chan.trans_x;
         dy_ff[0] <= req_chan.trans_y;
         dz_ff[0] <= req_chan.trans_z;
         for (int i = 1; i < CORDIC_LAT; i++) begin
            dx_ff[i] <= dx_ff[i-1];
            dy_ff[i] <= dy_ff[i-1];
            dz_ff[i] <= dz_ff[i-1];
         end
      end
   end

   ezh_cordic u_yaw   (.clock(clock), .en(adv), .angle(req_chan.yaw_angle),   .sc(yaw_sc));
   ezh_cordic u_pitch (.clock(clock), .en(adv), .angle(req_chan.pitch_angle), .sc(pitch_sc));
   ezh_cordic u_roll  (.clock(clock), .en(adv), .angle(req_chan.roll_angle),  .sc(roll_sc));

   ezh_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .valid_in  (dv_ff[CORDIC_LAT-1]),
      .yaw       (yaw_sc),
      .pitch     (pitch_sc),
      .roll      (roll_sc),
      .trans_x   (dx_ff[CORDIC_LAT-1]),
      .trans_y   (dy_ff[CORDIC_LAT-1]),
      .trans_z   (dz_ff[CORDIC_LAT-1]),
      .valid_out (m_valid),
      .result    (m_result)
   );

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_fire || !out_valid_ff) begin
         out_valid_ff  <= skid_valid_ff | m_valid;
         skid_valid_ff <= 1'b0;
      end else if (m_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : m_result;
      end else if (m_valid && !skid_valid_ff) begin
         skid_ff <= m_result;
      end
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.rot_00 = out_ff.rot_00;
   assign rsp_chan.rot_01 = out_ff.rot_01;
   assign rsp_chan.rot_02 = out_ff.rot_02;
   assign rsp_chan.rot_10 = out_ff.rot_10;
   assign rsp_chan.rot_11 = out_ff.rot_11;
   assign rsp_chan.rot_12 = out_ff.rot_12;
   assign rsp_chan.rot_20 = out_ff.rot_20;
   assign rsp_chan.rot_21 = out_ff.rot_21;
   assign rsp_chan.rot_22 = out_ff.rot_22;
   assign rsp_chan.out_x  = out_ff.out_x;
   assign rsp_chan.out_y  = out_ff.out_y;
   assign rsp_chan.out_z  = out_ff.out_z;

   // The skid entry is only ever occupied behind a full output register.
   `EZH_ASSERT_IMPLY(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   // A held skid entry is not dropped while the sink stalls.
   `EZH_ASSERT_NEXT(a_skid_holds, skid_valid_ff && !rsp_chan.ready, skid_valid_ff)
   // Draining the skid entry leaves a valid response behind.
   `EZH_ASSERT_NEXT(a_skid_drains, skid_valid_ff && rsp_chan.ready, out_valid_ff)
   // No new request is taken while the skid entry is full.
   `EZH_ASSERT_IMPLY(a_no_accept_full, skid_valid_ff, !req_chan.ready)

endmodule

/* tb/tb_euler_zyx_to_homogeneous_transform_top.sv */
// Self-checking testbench for the pose-to-transform block.
// Depends on ezh_pkg, ezh_req_if, ezh_rsp_if and euler_zyx_to_homogeneous_transform_top.
`timescale 1ns / 1ps

module tb_euler_zyx_to_homogeneous_transform_top;
   import ezh_pkg::*;

   localparam int  LATENCY    = 37;
   localparam int  NUM_RANDOM = 2000;
   localparam int  CYCLE_CAP  = 400000;
   localparam int  NUM_ROWS   = 16;

   typedef struct {
      trans_type tx;
      trans_type ty;
      trans_type tz;
      angle_type yaw;
      angle_type pitch;
      angle_type roll;
   } pose_type;

   // One directed row: pose, and optionally a hand-written expected matrix.
   typedef struct {
      pose_type pose;
      bit       typed;
      coef_type rot [9];
   } pose_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ezh_req_if req_chan ();
   ezh_rsp_if rsp_chan ();

   euler_zyx_to_homogeneous_transform_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rsp_type      expected_transforms [$];
   pose_row_type pose_rows [NUM_ROWS];
   int           errors       = 0;
   int           cycle_count  = 0;
   int           sent_count   = 0;
   int           recv_count   = 0;
   int           sink_gap     = 0;
   bit           hold_sink    = 1'b0;
   bit           no_idle      = 1'b0;

   // Floor division by a power of two.
   function automatic logic signed [63:0] fshift(logic signed [63:0] v, int n);
      return v >>> n;
   endfunction

   // Round half up by n fraction bits.
   function automatic logic signed [63:0] rshift(logic signed [63:0] v, int n);
      if (n == 0) begin
         return v;
      end
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   // Rotate the binary angle with the CORDIC and fold the quadrant.
   function automatic void angle_sincos(angle_type a, output logic signed [63:0] c,
                                        output logic signed [63:0] s);
      logic [31:0]          turn;
      logic signed [63:0]   x, y, z, dx, dy;
      turn = {a, {(32 - ANGLE_WIDTH){1'b0}}};
      z = {34'd0, turn[29:0]};
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - 64'(ATAN_TAB[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + 64'(ATAN_TAB[i]);
         end
      end
      case (turn[31:30])
         QUAD_0: begin c = x;  s = y;  end
         QUAD_1: begin c = -y; s = x;  end
         QUAD_2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Round to the coefficient format and saturate to plus or minus one.
   function automatic coef_type to_entry(logic signed [63:0] v, int frac);
      logic signed [63:0] r, lim;
      r = rshift(v, frac - COEF_FRAC);
      lim = 64'sd1 <<< COEF_FRAC;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r[COEF_WIDTH-1:0];
   endfunction

   // Compute the transform that a pose should produce.
   function automatic rsp_type pose_transform(pose_type p);
      logic signed [63:0] cy, sy, cp, sp, cr, sr, csp, ssp;
      rsp_type t;
      angle_sincos(p.yaw, cy, sy);
      angle_sincos(p.pitch, cp, sp);
      angle_sincos(p.roll, cr, sr);
      csp = rshift(cy * sp, 30);
      ssp = rshift(sy * sp, 30);
      t.rot_00 = to_entry(cy * cp, 60);
      t.rot_01 = to_entry(csp * sr - sy * cr, 60);
      t.rot_02 = to_entry(csp * cr + sy * sr, 60);
      t.rot_10 = to_entry(sy * cp, 60);
      t.rot_11 = to_entry(ssp * sr + cy * cr, 60);
      t.rot_12 = to_entry(ssp * cr - cy * sr, 60);
      t.rot_20 = to_entry(-sp, 30);
      t.rot_21 = to_entry(cp * sr, 60);
      t.rot_22 = to_entry(cp * cr, 60);
      t.out_x = p.tx;
      t.out_y = p.ty;
      t.out_z = p.tz;
      return t;
   endfunction

   function automatic pose_type random_pose();
      pose_type p;
      p.tx = $urandom;
      p.ty = $urandom;
      p.tz = $urandom;
      p.yaw = $urandom;
      p.pitch = $urandom;
      p.roll = $urandom;
      // Bias some angles toward the quadrant edges and the extremes.
      case ($urandom_range(0, 5))
         0: p.pitch = {2'($urandom_range(0, 3)), {(ANGLE_WIDTH - 2){1'b0}}}
                      + angle_type'($urandom_range(0, 4)) - 2;
         1: p.yaw = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: ;
      endcase
      return p;
   endfunction

   // Directed table: identity, extreme translations, every quadrant edge, minus pi.
   initial begin
      angle_type q;
      q = angle_type'(1 <<< (ANGLE_WIDTH - 2));
      pose_rows[0]  = '{'{32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0}, 1'b1,
                        '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}};
      pose_rows[1]  = '{'{32'sh80000000, 32'sh7FFFFFFF, 32'hFFFFFFFF, 0, 0, 0}, 1'b1,
                        '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}};
      pose_rows[2]  = '{'{0, 0, 0, q, 0, 0}, 1'b0, '{default: 0}};
      pose_rows[3]  = '{'{0, 0, 0, 0, q, 0}, 1'b0, '{default: 0}};
      pose_rows[4]  = '{'{0, 0, 0, 0, 0, q}, 1'b0, '{default: 0}};
      pose_rows[5]  = '{'{0, 0, 0, 16'sh8000, 0, 0}, 1'b0, '{default: 0}};
      pose_rows[6]  = '{'{0, 0, 0, 0, 16'sh8000, 0}, 1'b0, '{default: 0}};
      pose_rows[7]  = '{'{0, 0, 0, 0, 0, 16'sh8000}, 1'b0, '{default: 0}};
      pose_rows[8]  = '{'{1, 2, 3, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '{default: 0}};
      pose_rows[9]  = '{'{0, 0, 0, -q, -q, -q}, 1'b0, '{default: 0}};
      pose_rows[10] = '{'{0, 0, 0, 16'sh8001, 16'sh4001, 16'shBFFF}, 1'b0, '{default: 0}};
      pose_rows[11] = '{'{0, 0, 0, 1, -1, 1}, 1'b0, '{default: 0}};
      pose_rows[12] = '{'{0, 0, 0, 16'sh2000, 16'sh2000, 16'sh2000}, 1'b0, '{default: 0}};
      pose_rows[13] = '{'{32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F,
                          16'sh5555, 16'shAAAA, 16'sh3FFF}, 1'b0, '{default: 0}};
      pose_rows[14] = '{'{0, 0, 0, q, q, q}, 1'b0, '{default: 0}};
      pose_rows[15] = '{'{-1, -1, -1, 16'shFFFF, 16'shC000, 16'sh4000}, 1'b0,
                        '{default: 0}};
   end

   // Drive one transaction and wait for its acceptance, with random idling.
   task automatic send_pose(pose_type p);
      int gap;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.trans_x     <= p.tx;
      req_chan.trans_y     <= p.ty;
      req_chan.trans_z     <= p.tz;
      req_chan.yaw_angle   <= p.yaw;
      req_chan.pitch_angle <= p.pitch;
      req_chan.roll_angle  <= p.roll;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      sent_count++;
   endtask

   // Compare each received transaction with the oldest expected transform.
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type  want;
      coef_type got [9];
      coef_type exp [9];
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         recv_count++;
         if (expected_transforms.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %h", $time,
                     rsp_chan.rot_00);
            errors++;
         end else begin
            want = expected_transforms.pop_front();
            exp = '{want.rot_00, want.rot_01, want.rot_02, want.rot_10, want.rot_11,
                    want.rot_12, want.rot_20, want.rot_21, want.rot_22};
            got = '{rsp_chan.rot_00, rsp_chan.rot_01, rsp_chan.rot_02, rsp_chan.rot_10,
                    rsp_chan.rot_11, rsp_chan.rot_12, rsp_chan.rot_20, rsp_chan.rot_21,
                    rsp_chan.rot_22};
            for (int i = 0; i < 9; i++) begin
               check_field($sformatf("rot_%0d%0d", i / 3, i % 3), 32'(exp[i]), 32'(got[i]));
            end
            check_field("out_x", want.out_x, rsp_chan.out_x);
            check_field("out_y", want.out_y, rsp_chan.out_y);
            check_field("out_z", want.out_z, rsp_chan.out_z);
         end
      end
   end

   // Receiver: random bursts of idle cycles, one long hold, none near the end.
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_chan.ready <= 1'b1;
         sink_gap       <= 0;
      end else if (hold_sink) begin
         rsp_chan.ready <= 1'b0;
      end else if (sink_gap != 0) begin
         sink_gap       <= sink_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!rsp_chan.ready) begin
         rsp_chan.ready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         sink_gap       <= $urandom_range(0, 9);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      wait (sent_count == 300);
      hold_sink = 1'b1;
      repeat (120) @(posedge clock);
      hold_sink = 1'b0;
   end

   // Cycle counter with a generous limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("euler_zyx_to_homogeneous_transform_top regression: fail");
         $finish;
      end
   end

   initial begin
      pose_type p;
      rsp_type  t;
      req_chan.valid       = 1'b0;
      req_chan.trans_x     = '0;
      req_chan.trans_y     = '0;
      req_chan.trans_z     = '0;
      req_chan.yaw_angle   = '0;
      req_chan.pitch_angle = '0;
      req_chan.roll_angle  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; hand-typed matrices override the computed ones.
      for (int r = 0; r < NUM_ROWS; r++) begin
         p = pose_rows[r].pose;
         t = pose_transform(p);
         if (pose_rows[r].typed) begin
            {t.rot_00, t.rot_01, t.rot_02, t.rot_10, t.rot_11, t.rot_12, t.rot_20,
             t.rot_21, t.rot_22} = {pose_rows[r].rot[0], pose_rows[r].rot[1],
             pose_rows[r].rot[2], pose_rows[r].rot[3], pose_rows[r].rot[4],
             pose_rows[r].rot[5], pose_rows[r].rot[6], pose_rows[r].rot[7],
             pose_rows[r].rot[8]};
         end
         expected_transforms.push_back(t);
         send_pose(p);
      end

      // Random poses; pause once until the pipeline has drained.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 1000) begin
            req_chan.valid <= 1'b0;
            wait (expected_transforms.size() == 0);
            @(posedge clock);
         end
         if (n == NUM_RANDOM - 200) begin
            no_idle = 1'b1;
         end
         p = random_pose();
         expected_transforms.push_back(pose_transform(p));
         send_pose(p);
      end
      req_chan.valid <= 1'b0;

      wait (expected_transforms.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d poses incl. quadrant edges, -pi and extreme translations;",
               sent_count);
      $display("received %0d transforms under random and long backpressure.", recv_count);
      if (errors == 0) begin
         $display("euler_zyx_to_homogeneous_transform_top regression: pass");
      end else begin
         $display("euler_zyx_to_homogeneous_transform_top regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/ezh_pkg.sv
design/ezh_req_if.sv
design/ezh_rsp_if.sv
design/ezh_cordic.sv
design/ezh_matrix.sv
design/euler_zyx_to_homogeneous_transform_top.sv
tb/tb_euler_zyx_to_homogeneous_transform_top.sv
